FILE: sv/tiled_pattern_overlay_cmyk_defines.svh
// Assertion macros shared by the tiled pattern overlay RTL.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef TILED_PATTERN_OVERLAY_CMYK_DEFINES_SVH
`define TILED_PATTERN_OVERLAY_CMYK_DEFINES_SVH
`ifndef SYNTH
// Check a property at every clock edge outside reset.
`define TPOC_ASSERT(LBL, PROP, MSG) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) PROP) else $error(MSG);
// Check that a condition in one cycle implies another in the same cycle.
`define TPOC_IMPLIES(LBL, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANTE) |-> (CONS)) \
        else $error(MSG);
`else
`define TPOC_ASSERT(LBL, PROP, MSG)
`define TPOC_IMPLIES(LBL, ANTE, CONS, MSG)
`endif
`endif

FILE: sv/tpoc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the tiled pattern overlay block.
// No dependencies.
package tpoc_pkg;

    localparam int MAP_AW    = 16;
    localparam int MAP_DEPTH = 1 << MAP_AW;
    localparam int CFG_DW    = 15;
    localparam int CFG_IW    = 3;

    localparam logic [15:0] W_RED   = 16'd13933;
    localparam logic [15:0] W_GREEN = 16'd46871;
    localparam logic [15:0] W_BLUE  = 16'd4732;

    localparam logic [7:0] INK_FULL = 8'd255;
    localparam logic [7:0] INK_NONE = 8'd0;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_COMPOSE = 1'b1;

    typedef enum logic [CFG_IW-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_TILE_WIDTH    = 3'd2,
        CFG_TILE_HEIGHT   = 3'd3,
        CFG_SCALE_FACTOR  = 3'd4,
        CFG_TILE_IS_RGB   = 3'd5,
        CFG_DOT_THRESHOLD = 3'd6
    } t_cfg_idx;

    // Raw geometry registers as written by software.
    typedef struct packed {
        logic [14:0] image_width;
        logic [14:0] image_height;
        logic [8:0]  tile_width;
        logic [8:0]  tile_height;
        logic [4:0]  scale_factor;
    } t_geom_cfg;

    // Position of the current raster pixel as seen by the map lookup.
    typedef struct packed {
        logic [MAP_AW-1:0] taddr;
        logic              row_end;
        logic              frame_end;
    } t_pix_pos;

endpackage

FILE: sv/tpoc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpoc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/tpoc_dot.sv
`timescale 1ns / 1ps
// Luminance and dot decision for one tile sample: weights registered, sum and compare next.
// Depends on tpoc_pkg.
module tpoc_dot
    import tpoc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic       i_is_rgb,
    input  logic [8:0] i_threshold,
    output logic       o_dot
);

    logic [23:0] r_prod_r;
    logic [23:0] r_prod_g;
    logic [23:0] r_prod_b;
    logic [7:0]  r_gray;
    logic        r_is_rgb;
    logic [23:0] w_sum;
    logic [7:0]  w_lum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_r <= 24'(i_red)   * 24'(W_RED);
            r_prod_g <= 24'(i_green) * 24'(W_GREEN);
            r_prod_b <= 24'(i_blue)  * 24'(W_BLUE);
            r_gray   <= i_red;
            r_is_rgb <= i_is_rgb;
        end
    end

    // Weighted sum stays below 2^24, so the top byte is the truncated luminance.
    assign w_sum = r_prod_r + r_prod_g + r_prod_b;
    assign w_lum = r_is_rgb ? w_sum[23:16] : r_gray;
    assign o_dot = ({1'b0, w_lum} < i_threshold);

endmodule

FILE: sv/tpoc_raster.sv
`timescale 1ns / 1ps
// Raster and repeating tile position counters, and the dot map address of the pixel.
// Depends on tpoc_pkg and tiled_pattern_overlay_cmyk_defines.svh.
`include "tiled_pattern_overlay_cmyk_defines.svh"
module tpoc_raster
    import tpoc_pkg::*;
#(
    parameter int MAX_TILE_SIDE  = 256,
    parameter int MAX_IMAGE_SIDE = 16384,
    parameter int MAX_SCALE      = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_geom_cfg i_cfg,
    output t_pix_pos  o_pos
);

    localparam int CNT_W = $clog2(MAX_IMAGE_SIDE);
    localparam int CW    = CNT_W + 1;
    localparam int TC_W  = (MAX_TILE_SIDE > 1) ? $clog2(MAX_TILE_SIDE) : 1;
    localparam int TL_W  = TC_W + 1;
    localparam int SC_W  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int SL_W  = SC_W + 1;

    logic [CNT_W-1:0] r_col, r_row, n_col, n_row;
    logic [SC_W-1:0]  r_sub_col, r_sub_row, n_sub_col, n_sub_row;
    logic [TC_W-1:0]  r_tile_col, r_tile_row, n_tile_col, n_tile_row;

    logic [CW-1:0]   w_iw, w_ih, w_col_inc, w_row_inc;
    logic [TL_W-1:0] w_tw, w_th, w_tcol_inc, w_trow_inc;
    logic [SL_W-1:0] w_sc, w_scol_inc, w_srow_inc;
    logic [31:0]     w_taddr_full;
    logic            w_row_end, w_frame_end;

    // Saturate the limits to 1..maximum.
    always_comb begin
        if (i_cfg.image_width == '0) begin
            w_iw = CW'(1);
        end else if (32'(i_cfg.image_width) > 32'(MAX_IMAGE_SIDE)) begin
            w_iw = CW'(MAX_IMAGE_SIDE);
        end else begin
            w_iw = CW'(i_cfg.image_width);
        end
        if (i_cfg.image_height == '0) begin
            w_ih = CW'(1);
        end else if (32'(i_cfg.image_height) > 32'(MAX_IMAGE_SIDE)) begin
            w_ih = CW'(MAX_IMAGE_SIDE);
        end else begin
            w_ih = CW'(i_cfg.image_height);
        end
        if (i_cfg.tile_width == '0) begin
            w_tw = TL_W'(1);
        end else if (32'(i_cfg.tile_width) > 32'(MAX_TILE_SIDE)) begin
            w_tw = TL_W'(MAX_TILE_SIDE);
        end else begin
            w_tw = TL_W'(i_cfg.tile_width);
        end
        if (i_cfg.tile_height == '0) begin
            w_th = TL_W'(1);
        end else if (32'(i_cfg.tile_height) > 32'(MAX_TILE_SIDE)) begin
            w_th = TL_W'(MAX_TILE_SIDE);
        end else begin
            w_th = TL_W'(i_cfg.tile_height);
        end
        if (i_cfg.scale_factor == '0) begin
            w_sc = SL_W'(1);
        end else if (32'(i_cfg.scale_factor) > 32'(MAX_SCALE)) begin
            w_sc = SL_W'(MAX_SCALE);
        end else begin
            w_sc = SL_W'(i_cfg.scale_factor);
        end
    end

    assign w_col_inc  = CW'(r_col) + CW'(1);
    assign w_row_inc  = CW'(r_row) + CW'(1);
    assign w_scol_inc = SL_W'(r_sub_col) + SL_W'(1);
    assign w_srow_inc = SL_W'(r_sub_row) + SL_W'(1);
    assign w_tcol_inc = TL_W'(r_tile_col) + TL_W'(1);
    assign w_trow_inc = TL_W'(r_tile_row) + TL_W'(1);

    // Counters can sit beyond a lowered limit, so wrap on reach-or-exceed.
    assign w_row_end   = (w_col_inc >= w_iw);
    assign w_frame_end = w_row_end && (w_row_inc >= w_ih);

    // One small multiplier; the address wraps to the map depth.
    assign w_taddr_full = 32'(r_tile_row) * 32'(w_tw) + 32'(r_tile_col);

    assign o_pos.taddr     = w_taddr_full[MAP_AW-1:0];
    assign o_pos.row_end   = w_row_end;
    assign o_pos.frame_end = w_frame_end;

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_sub_col  = r_sub_col;
        n_sub_row  = r_sub_row;
        n_tile_col = r_tile_col;
        n_tile_row = r_tile_row;
        if (!w_row_end) begin
            n_col = w_col_inc[CNT_W-1:0];
            if (w_scol_inc >= w_sc) begin
                n_sub_col  = '0;
                n_tile_col = (w_tcol_inc >= w_tw) ? '0 : w_tcol_inc[TC_W-1:0];
            end else begin
                n_sub_col = w_scol_inc[SC_W-1:0];
            end
        end else begin
            n_col      = '0;
            n_sub_col  = '0;
            n_tile_col = '0;
            if (w_frame_end) begin
                n_row      = '0;
                n_sub_row  = '0;
                n_tile_row = '0;
            end else begin
                n_row = w_row_inc[CNT_W-1:0];
                if (w_srow_inc >= w_sc) begin
                    n_sub_row  = '0;
                    n_tile_row = (w_trow_inc >= w_th) ? '0 : w_trow_inc[TC_W-1:0];
                end else begin
                    n_sub_row = w_srow_inc[SC_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_sub_col  <= '0;
            r_sub_row  <= '0;
            r_tile_col <= '0;
            r_tile_row <= '0;
        end else if (i_step) begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_sub_col  <= n_sub_col;
            r_sub_row  <= n_sub_row;
            r_tile_col <= n_tile_col;
            r_tile_row <= n_tile_row;
        end
    end

    `TPOC_ASSERT(a_row_restart,
        $past(i_step && w_row_end) |-> (r_col == '0 && r_tile_col == '0),
        "row end did not restart the column counters")
    `TPOC_ASSERT(a_frame_restart,
        $past(i_step && w_frame_end) |-> (r_row == '0 && r_tile_row == '0),
        "frame end did not restart the row counters")
    `TPOC_IMPLIES(a_frame_end_on_row_end, w_frame_end, w_row_end,
        "frame end flagged away from a row end")

endmodule

FILE: sv/tiled_pattern_overlay_cmyk.sv
`timescale 1ns / 1ps
// Top level of the tiled pattern overlay: config registers, pipeline, dot map memory.
// Depends on tpoc_pkg, tpoc_ram, tpoc_dot, tpoc_raster and the defines header.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | i_valid / o_stall      | i_func, i_tile_addr, i_red, i_green, i_blue
//  output   | o_valid / i_stall      | o_cyan, o_magenta, o_yellow, o_black,
//           |                        | o_row_end, o_frame_end
//  config   | i_cfg_we               | i_cfg_index, i_cfg_data
//
// One transaction per clock in each direction unless stalled. A compose transaction
// passes stage 1, stage 2 and the output register; a load transaction produces no output.
// The single map memory port pair sets the rate: a load writes and a compose reads in
// the stage after acceptance, one of them per cycle.
// Reset (i_rst_n low at a clock edge) returns counters and config to their defaults and
// clears valid flags; the map contents stay undefined until loaded.
// o_stall is high only while a result sits in the output register and i_stall is high;
// the whole pipeline holds in that cycle.
`include "tiled_pattern_overlay_cmyk_defines.svh"
module tiled_pattern_overlay_cmyk
    import tpoc_pkg::*;
#(
    parameter int MAX_TILE_SIDE  = 256,
    parameter int MAX_IMAGE_SIDE = 16384,
    parameter int MAX_SCALE      = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input transactions
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_func,
    input  logic [15:0]       i_tile_addr,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_blue,
    // output transactions
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_cyan,
    output logic [7:0]        o_magenta,
    output logic [7:0]        o_yellow,
    output logic [7:0]        o_black,
    output logic              o_row_end,
    output logic              o_frame_end,
    // configuration writes
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    // Configuration registers
    t_geom_cfg  r_geom;
    logic       r_tile_is_rgb;
    logic [8:0] r_dot_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.image_width  <= 15'd1;
            r_geom.image_height <= 15'd1;
            r_geom.tile_width   <= 9'd1;
            r_geom.tile_height  <= 9'd1;
            r_geom.scale_factor <= 5'd1;
            r_tile_is_rgb       <= 1'b0;
            r_dot_threshold     <= 9'd128;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:   r_geom.image_width  <= i_cfg_data[14:0];
                CFG_IMAGE_HEIGHT:  r_geom.image_height <= i_cfg_data[14:0];
                CFG_TILE_WIDTH:    r_geom.tile_width   <= i_cfg_data[8:0];
                CFG_TILE_HEIGHT:   r_geom.tile_height  <= i_cfg_data[8:0];
                CFG_SCALE_FACTOR:  r_geom.scale_factor <= i_cfg_data[4:0];
                CFG_TILE_IS_RGB:   r_tile_is_rgb       <= i_cfg_data[0];
                CFG_DOT_THRESHOLD: r_dot_threshold     <= i_cfg_data[8:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // Flow control: every stage advances unless a result is stuck at the output.
    logic w_advance;
    logic w_accept;
    logic w_step;

    assign w_advance = !o_valid || !i_stall;
    assign o_stall   = !w_advance;
    assign w_accept  = i_valid && w_advance;
    assign w_step    = w_accept && (i_func == FUNC_COMPOSE);

    // Raster position of the pixel being taken
    t_pix_pos w_pos;

    tpoc_raster #(
        .MAX_TILE_SIDE  (MAX_TILE_SIDE),
        .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE),
        .MAX_SCALE      (MAX_SCALE)
    ) u_raster (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_cfg   (r_geom),
        .o_pos   (w_pos)
    );

    // Stage 1: transaction taken; map address chosen, luminance weights in flight
    logic              r_s1_valid;
    logic              r_s1_func;
    logic [MAP_AW-1:0] r_s1_addr;
    logic [7:0]        r_s1_red, r_s1_green, r_s1_blue;
    logic              r_s1_row_end, r_s1_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_advance) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s1_func      <= i_func;
            r_s1_addr      <= (i_func == FUNC_LOAD) ? i_tile_addr : w_pos.taddr;
            r_s1_red       <= i_red;
            r_s1_green     <= i_green;
            r_s1_blue      <= i_blue;
            r_s1_row_end   <= w_pos.row_end;
            r_s1_frame_end <= w_pos.frame_end;
        end
    end

    logic w_new_dot;

    tpoc_dot u_dot (
        .i_clk       (i_clk),
        .i_en        (w_advance),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_is_rgb    (r_tile_is_rgb),
        .i_threshold (r_dot_threshold),
        .o_dot       (w_new_dot)
    );

    // Dot map: loads write and composes read from stage 1, so a compose always sees
    // every load taken before it.
    logic w_ram_we, w_ram_re;
    logic w_map_dot;

    assign w_ram_we = w_advance && r_s1_valid && (r_s1_func == FUNC_LOAD);
    assign w_ram_re = w_advance && r_s1_valid && (r_s1_func == FUNC_COMPOSE);

    tpoc_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_s1_addr),
        .i_wdata (w_new_dot),
        .i_re    (w_ram_re),
        .i_raddr (r_s1_addr),
        .o_rdata (w_map_dot)
    );

    // Stage 2: map bit arrives; only composes carry on
    logic       r_s2_valid;
    logic [7:0] r_s2_red, r_s2_green, r_s2_blue;
    logic       r_s2_row_end, r_s2_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_advance) begin
            r_s2_valid <= r_s1_valid && (r_s1_func == FUNC_COMPOSE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s2_red       <= r_s1_red;
            r_s2_green     <= r_s1_green;
            r_s2_blue      <= r_s1_blue;
            r_s2_row_end   <= r_s1_row_end;
            r_s2_frame_end <= r_s1_frame_end;
        end
    end

    // Output register: black on a dot, inverted background otherwise
    logic       r_out_valid;
    logic [7:0] r_out_cyan, r_out_magenta, r_out_yellow, r_out_black;
    logic       r_out_row_end, r_out_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_cyan      <= w_map_dot ? INK_NONE : ~r_s2_red;
            r_out_magenta   <= w_map_dot ? INK_NONE : ~r_s2_green;
            r_out_yellow    <= w_map_dot ? INK_NONE : ~r_s2_blue;
            r_out_black     <= w_map_dot ? INK_FULL : INK_NONE;
            r_out_row_end   <= r_s2_row_end;
            r_out_frame_end <= r_s2_frame_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_cyan      = r_out_cyan;
    assign o_magenta   = r_out_magenta;
    assign o_yellow    = r_out_yellow;
    assign o_black     = r_out_black;
    assign o_row_end   = r_out_row_end;
    assign o_frame_end = r_out_frame_end;

    `TPOC_ASSERT(a_map_one_access, !(w_ram_we && w_ram_re),
        "map written and read in one cycle")
    `TPOC_IMPLIES(a_frame_in_row, o_valid && o_frame_end, o_row_end,
        "frame end without row end")
    `TPOC_IMPLIES(a_dot_is_black, o_valid && o_black != INK_NONE,
        o_cyan == INK_NONE && o_magenta == INK_NONE && o_yellow == INK_NONE,
        "dot pixel carries color ink")

endmodule
